// ===== rtl/dlz_pkg.sv =====
package dlz_pkg;

  localparam int QW_C0 = 61;
  localparam int QW_RT = 32;
  localparam int QW_RM = 62;

  localparam int CW  = 39;
  localparam int LNW = 40;

  localparam logic [CW-1:0] C0_Q = 39'd327191002584;
  localparam logic [5:1][CW-1:0] COEF_MAG = {
    39'd23172, 39'd5191116, 39'd5290281181, 39'd103139766587, 39'd371537521745
  };
  localparam logic [5:1] COEF_NEG = 5'b10101;

  localparam logic [31:0] LN2_Q = 32'd2977044472;
  localparam logic [63:0] ONE_Q = 64'h0000_0001_0000_0000;

  localparam int LAT_DIV_C0 = QW_C0 + 1;
  localparam int LAT_DIV_RT = QW_RT + 1;
  localparam int LAT_DIV_RM = QW_RM + 1;

  localparam int LAT_SER = 2 * LAT_DIV_RT + 4;
  localparam int LAT_LOG = 36;
  localparam int LAT_ARM = LAT_SER + LAT_DIV_RM;
  localparam int DLY_LOG = LAT_ARM - LAT_LOG;
  localparam int DLY_RAT = LAT_ARM - LAT_DIV_RT;
  localparam int LAT_TOT = LAT_ARM + 4;

endpackage

// ===== rtl/dlz_div.sv =====
module dlz_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic [QW-1:0] quo,
  output logic          over,
  output logic [SW-1:0] side_out
);

  localparam int IW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [IW-1:0] rem_r  [QW+1];
  logic [DW-1:0] den_r  [QW+1];
  logic [QW-1:0] quo_r  [QW+1];
  logic          over_r [QW+1];
  logic [SW-1:0] side_r [QW+1];

  // overflow when the quotient needs more than QW bits
  always_ff @(posedge clk) begin
    rem_r[0]  <= IW'(num);
    den_r[0]  <= den;
    quo_r[0]  <= '0;
    over_r[0] <= IW'(num) >= (IW'(den) << QW);
    side_r[0] <= side_in;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int B = QW - k;
    logic [IW-1:0] trial;
    logic          fits;
    assign trial = IW'(den_r[k-1]) << B;
    assign fits  = rem_r[k-1] >= trial;
    always_ff @(posedge clk) begin
      rem_r[k]  <= fits ? rem_r[k-1] - trial : rem_r[k-1];
      den_r[k]  <= den_r[k-1];
      quo_r[k]  <= quo_r[k-1] | (QW'(fits) << B);
      over_r[k] <= over_r[k-1];
      side_r[k] <= side_r[k-1];
    end
  end

  assign quo      = quo_r[QW];
  assign over     = over_r[QW];
  assign side_out = side_r[QW];

endmodule

// ===== rtl/dlz_series.sv =====
module dlz_series
  import dlz_pkg::*;
#(
  parameter int VW = 48
) (
  input  logic          clk,
  input  logic [VW-1:0] v,
  output logic [62:0]   vs,
  output logic [61:0]   qmag,
  output logic          qneg
);

  localparam int DW     = VW + 1;
  localparam int C0_DLY = 2 * LAT_DIV_RT + 2 - LAT_DIV_C0;

  logic [63:0]        vsbase;
  logic [DW-1:0]      dj       [1:5];
  logic [31:0]        r_q      [1:5];
  logic [64+DW-1:0]   r_side   [1:5];
  logic [31:0]        inv_q    [1:5];
  logic [95:0]        inv_side [1:5];

  logic [63:0]        prl_r    [1:5];
  logic [38:0]        prh_r    [1:5];
  logic [63:0]        pil_r    [1:5];
  logic [38:0]        pih_r    [1:5];
  logic [39:0]        t1_r     [1:5];
  logic [39:0]        t2_r     [1:5];
  logic [63:0]        vsb1_r, vsb2_r;

  logic [QW_C0-1:0]   c0_q;
  logic               c0_over;
  logic [61:0]        c0d_r    [C0_DLY];

  logic signed [63:0] vs_sum, vq_sum;
  logic signed [63:0] vs_s_r, vq_s_r;
  logic [62:0]        vs_r;
  logic [61:0]        qmag_r;
  logic               qneg_r;

  assign vsbase = 64'(v) + 64'(v >> 32) + 64'(C0_Q);

  dlz_div #(.NW(CW + 32), .DW(VW), .QW(QW_C0), .SW(1)) u_c0_div (
    .clk      (clk),
    .num      ({C0_Q, 32'b0}),
    .den      (v),
    .side_in  (1'b0),
    .quo      (c0_q),
    .over     (c0_over),
    .side_out ()
  );

  always_ff @(posedge clk) begin
    c0d_r[0] <= c0_over ? (62'd1 << 61) : {1'b0, c0_q};
    for (int i = 1; i < C0_DLY; i++) c0d_r[i] <= c0d_r[i-1];
  end

  for (genvar j = 1; j <= 5; j++) begin : g_term
    assign dj[j] = DW'(v) + (DW'(j) << 32);

    dlz_div #(.NW(VW + 32), .DW(DW), .QW(QW_RT), .SW(64 + DW)) u_r_div (
      .clk      (clk),
      .num      ({v, 32'b0}),
      .den      (dj[j]),
      .side_in  ({vsbase, dj[j]}),
      .quo      (r_q[j]),
      .over     (),
      .side_out (r_side[j])
    );

    dlz_div #(.NW(64), .DW(DW), .QW(QW_RT), .SW(96)) u_inv_div (
      .clk      (clk),
      .num      ({r_q[j], 32'b0}),
      .den      (r_side[j][DW-1:0]),
      .side_in  ({r_side[j][64+DW-1:DW], r_q[j]}),
      .quo      (inv_q[j]),
      .over     (),
      .side_out (inv_side[j])
    );

    always_ff @(posedge clk) begin
      prl_r[j] <= 64'(inv_side[j][31:0]) * 64'(COEF_MAG[j][31:0]);
      prh_r[j] <= 39'(inv_side[j][31:0]) * 39'(COEF_MAG[j][CW-1:32]);
      pil_r[j] <= 64'(inv_q[j]) * 64'(COEF_MAG[j][31:0]);
      pih_r[j] <= 39'(inv_q[j]) * 39'(COEF_MAG[j][CW-1:32]);
      t1_r[j]  <= 40'(prh_r[j]) + 40'(prl_r[j][63:32]);
      t2_r[j]  <= 40'(pih_r[j]) + 40'(pil_r[j][63:32]);
    end
  end

  always_ff @(posedge clk) begin
    vsb1_r <= inv_side[1][95:32];
    vsb2_r <= vsb1_r;
  end

  always_comb begin
    vs_sum = signed'(vsb2_r);
    vq_sum = signed'(64'(c0d_r[C0_DLY-1]));
    for (int j = 1; j <= 5; j++) begin
      if (COEF_NEG[j]) begin
        vs_sum = vs_sum - signed'(64'(t1_r[j]));
        vq_sum = vq_sum - signed'(64'(t2_r[j]));
      end else begin
        vs_sum = vs_sum + signed'(64'(t1_r[j]));
        vq_sum = vq_sum + signed'(64'(t2_r[j]));
      end
    end
  end

  always_ff @(posedge clk) begin
    vs_s_r <= vs_sum;
    vq_s_r <= vq_sum;
    vs_r   <= (vs_s_r < 64'sd1) ? 63'd1 : vs_s_r[62:0];
    qneg_r <= vq_s_r[63];
    qmag_r <= vq_s_r[63] ? 62'(-vq_s_r) : vq_s_r[61:0];
  end

  assign vs   = vs_r;
  assign qmag = qmag_r;
  assign qneg = qneg_r;

endmodule

// ===== rtl/dlz_log.sv =====
module dlz_log
  import dlz_pkg::*;
#(
  parameter int TW = 49
) (
  input  logic           clk,
  input  logic [TW-1:0]  t,
  output logic [LNW-1:0] lnv
);

  localparam int PW = $clog2(TW);

  logic [PW-1:0]    lead;
  logic [PW-1:0]    lead_r;
  logic [TW-1:0]    t1_r;
  logic [31:0]      man_r  [33];
  logic [31:0]      frac_r [33];
  logic [PW-1:0]    exp_r  [33];
  logic [63:0]      plo_r;
  logic [PW+31:0]   phi_r;
  logic [LNW-1:0]   lnv_r;

  always_comb begin
    lead = '0;
    for (int i = 0; i < TW; i++) begin
      if (t[i]) lead = PW'(i);
    end
  end

  always_ff @(posedge clk) begin
    lead_r    <= lead;
    t1_r      <= t;
    man_r[0]  <= 32'(t1_r >> (lead_r - PW'(31)));
    exp_r[0]  <= lead_r - PW'(32);
    frac_r[0] <= '0;
  end

  // one fraction bit per squaring
  for (genvar k = 1; k <= 32; k++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] m2;
    assign sq = 64'(man_r[k-1]) * 64'(man_r[k-1]);
    assign m2 = sq[63:31];
    always_ff @(posedge clk) begin
      man_r[k]  <= m2[32] ? m2[32:1] : m2[31:0];
      frac_r[k] <= frac_r[k-1] | (32'(m2[32]) << (32 - k));
      exp_r[k]  <= exp_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    plo_r <= 64'(frac_r[32]) * 64'(LN2_Q);
    phi_r <= (PW + 32)'(exp_r[32]) * (PW + 32)'(LN2_Q);
    lnv_r <= LNW'(phi_r) + LNW'(plo_r[63:32]);
  end

  assign lnv = lnv_r;

endmodule

// ===== rtl/digamma_lanczos_core.sv =====
// Digamma core: psi(v) as the derivative of the six-term Lanczos log-gamma
// approximation, unsigned Q16.16 in, signed Q16.16 out (saturated).
// Input: a transaction is taken on a rising edge with start high and busy low.
// in_argument is the argument v; zero gives result 0 with out_domain_error set.
// Output: out_strobe is high for one cycle with out_digamma_value and
// out_domain_error; the receiver cannot stall and takes it on that edge.
// Throughput: one argument per cycle while busy is low. The latency is set
// by the bit-serial dividers in series: v/(v+j), its quotient divided by v+j
// again and the final divide of the q sum by the s sum, one quotient bit per
// stage, followed by the sum and rounding stages. The log term runs in
// parallel as 32 squaring stages and is delayed to match.
// Reset: synchronous, active low. Clears every transaction in flight; busy
// is high during reset and low from the first cycle after it.
module digamma_lanczos_core
  import dlz_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        in_argument,
  output logic               out_strobe,
  output logic signed [31:0] out_digamma_value,
  output logic               out_domain_error
);

  localparam int SH = 32 - FRAC_BITS;
  localparam int VW = 32 + SH;
  localparam int TW = VW + 1;

  logic                accept;
  logic                busy_r;
  logic [VW-1:0]       v_nxt, half;
  logic [TW-1:0]       t_nxt;
  logic [VW-1:0]       v_r, nmag_r;
  logic [TW-1:0]       t_r;
  logic                vlow_r;
  logic                vld_r  [LAT_TOT];
  logic                zero_r [LAT_TOT];

  logic [62:0]         vs;
  logic [61:0]         qmag;
  logic                qneg;
  logic [QW_RM-1:0]    rm_q;
  logic                rm_over, rm_neg;
  logic [LNW-1:0]      lnv;
  logic [QW_RT-1:0]    rat_q;
  logic                rat_neg;
  logic signed [32:0]  rat_s;
  logic signed [32:0]  rat_d_r [DLY_RAT];
  logic [LNW-1:0]      lnv_d_r [DLY_LOG];

  logic [62:0]         rm_mag;
  logic signed [63:0]  rterm_r, y_r, x_val, q_val;
  logic [LNW-1:0]      lnv1_r;
  logic signed [32:0]  rat1_r;
  logic signed [31:0]  val_nxt, val_r;

  assign accept = start & ~busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_comb begin
    v_nxt = VW'(in_argument) << SH;
    half  = VW'(1) << 31;
    t_nxt = TW'(v_nxt) + (TW'(9) << 31);
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    t_r    <= t_nxt;
    vlow_r <= v_nxt < half;
    nmag_r <= (v_nxt >= half) ? v_nxt - half : half - v_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT_TOT; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= accept;
      for (int i = 1; i < LAT_TOT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    zero_r[0] <= in_argument == 32'd0;
    for (int i = 1; i < LAT_TOT; i++) zero_r[i] <= zero_r[i-1];
  end

  dlz_series #(.VW(VW)) u_ser (
    .clk  (clk),
    .v    (v_r),
    .vs   (vs),
    .qmag (qmag),
    .qneg (qneg)
  );

  dlz_div #(.NW(94), .DW(63), .QW(QW_RM), .SW(1)) u_rm_div (
    .clk      (clk),
    .num      ({qmag, 32'b0}),
    .den      (vs),
    .side_in  (qneg),
    .quo      (rm_q),
    .over     (rm_over),
    .side_out (rm_neg)
  );

  dlz_log #(.TW(TW)) u_log (
    .clk (clk),
    .t   (t_r),
    .lnv (lnv)
  );

  dlz_div #(.NW(VW + 32), .DW(TW), .QW(QW_RT), .SW(1)) u_rat_div (
    .clk      (clk),
    .num      ({nmag_r, 32'b0}),
    .den      (t_r),
    .side_in  (vlow_r),
    .quo      (rat_q),
    .over     (),
    .side_out (rat_neg)
  );

  assign rat_s = rat_neg ? -signed'({1'b0, rat_q}) : signed'({1'b0, rat_q});

  always_ff @(posedge clk) begin
    rat_d_r[0] <= rat_s;
    for (int i = 1; i < DLY_RAT; i++) rat_d_r[i] <= rat_d_r[i-1];
    lnv_d_r[0] <= lnv;
    for (int i = 1; i < DLY_LOG; i++) lnv_d_r[i] <= lnv_d_r[i-1];
  end

  assign rm_mag = rm_over ? (63'd1 << 62) : {1'b0, rm_q};

  always_ff @(posedge clk) begin
    rterm_r <= rm_neg ? -signed'(64'(rm_mag)) : signed'(64'(rm_mag));
    lnv1_r  <= lnv_d_r[DLY_LOG-1];
    rat1_r  <= rat_d_r[DLY_RAT-1];
    y_r     <= signed'(64'(lnv1_r)) - signed'(ONE_Q) + 64'(rat1_r) - rterm_r;
  end

  // round to nearest, ties up, then saturate; a zero argument gives 0
  always_comb begin
    x_val = y_r + signed'(64'd1 << (SH - 1));
    q_val = x_val >>> SH;
    if (zero_r[LAT_TOT-2]) begin
      val_nxt = 32'sd0;
    end else if (q_val > 64'sd2147483647) begin
      val_nxt = 32'sh7FFF_FFFF;
    end else if (q_val < -64'sd2147483648) begin
      val_nxt = 32'sh8000_0000;
    end else begin
      val_nxt = q_val[31:0];
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign out_strobe        = vld_r[LAT_TOT-1];
  assign out_digamma_value = val_r;
  assign out_domain_error  = zero_r[LAT_TOT-1];

endmodule

// ===== rtl/dlz_checker.sv =====
module dlz_checker
  import dlz_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [31:0]        in_argument,
  input logic               out_strobe,
  input logic signed [31:0] out_digamma_value,
  input logic               out_domain_error
);

  a_zero_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_argument == 32'd0 |-> ##LAT_TOT (out_strobe && out_domain_error))
    else $error("zero argument transaction not flagged");

  a_nonzero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_argument != 32'd0 |-> ##LAT_TOT (out_strobe && !out_domain_error))
    else $error("result missing or wrongly flagged");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LAT_TOT !out_strobe)
    else $error("result without transaction");

  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_domain_error |-> out_digamma_value == 32'sd0)
    else $error("domain error with non-zero value");

endmodule

bind digamma_lanczos_core dlz_checker u_dlz_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int FRAC = 16;
  localparam int SH = 32 - FRAC;
  localparam logic [63:0] MAGMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] QONE = 64'h0000_0001_0000_0000;
  localparam logic [63:0] S0Q = 64'd4294967297;
  localparam logic [63:0] LN2Q = 64'd2977044472;
  localparam logic [63:0] TOFF = 64'd9 << 31;
  localparam logic [63:0] HALFQ = 64'd1 << 31;
  localparam logic [63:0] C0V_CAP = 64'd1 << 61;
  localparam logic [63:0] RAT_CAP = 64'd1 << 62;
  localparam int N_RANDOM = 1650;

  typedef struct packed {
    logic signed [31:0] psi;
    logic               derr;
  } psi_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [31:0] in_argument = '0;
  logic busy, out_strobe, out_domain_error;
  logic signed [31:0] out_digamma_value;

  logic [31:0] arg_q[$];
  psi_res_t psi_expect_q[$];
  int n_fail = 0;
  bit stim_done = 1'b0;
  bit calm = 1'b0;

  digamma_lanczos_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_argument(in_argument), .out_strobe(out_strobe),
    .out_digamma_value(out_digamma_value), .out_domain_error(out_domain_error)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] mdiv(logic [63:0] a, logic [63:0] b, logic [63:0] c);
    logic [127:0] p, q;
    if (c == 0) return MAGMAX;
    p = 128'(a) * 128'(b);
    q = p / 128'(c);
    if (q > 128'(MAGMAX)) return MAGMAX;
    return q[63:0];
  endfunction

  function automatic logic [63:0] lg2(logic [63:0] x);
    int p;
    logic [63:0] man, fr;
    fr = 0;
    if (x < QONE) return 0;
    p = 63;
    while (p > 0 && !x[p]) p--;
    man = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
    for (int i = 31; i >= 0; i--) begin
      man = (man * man) >> 31;
      if (man >= QONE) begin
        man = man >> 1;
        fr[i] = 1'b1;
      end
    end
    return (64'(p - 32) << 32) | fr;
  endfunction

  function automatic psi_res_t digamma_of(logic [31:0] a);
    logic signed [63:0] cf[6];
    logic [63:0] v, t, c0v, lnv, rmag, nmag, qmag, d, r, inv, cm;
    logic signed [63:0] vs, vq, ratio, rterm, y, x, q;
    psi_res_t res;
    cf = '{64'sd327191002584, -64'sd371537521745, 64'sd103139766587,
           -64'sd5290281181, 64'sd5191116, -64'sd23172};
    if (a == 0) begin
      res.psi = 0;
      res.derr = 1'b1;
      return res;
    end
    v = 64'(a) << SH;
    vs = $signed(mdiv(v, S0Q, QONE)) + cf[0];
    c0v = mdiv(cf[0], QONE, v);
    if (c0v > C0V_CAP) c0v = C0V_CAP;
    vq = $signed(c0v);
    for (int j = 1; j < 6; j++) begin
      d = v + (64'(j) << 32);
      r = mdiv(v, QONE, d);
      inv = mdiv(r, QONE, d);
      cm = (cf[j] < 0) ? -cf[j] : cf[j];
      if (cf[j] < 0) begin
        vs = vs - $signed(mdiv(cm, r, QONE));
        vq = vq - $signed(mdiv(cm, inv, QONE));
      end else begin
        vs = vs + $signed(mdiv(cm, r, QONE));
        vq = vq + $signed(mdiv(cm, inv, QONE));
      end
    end
    if (vs < 1) vs = 1;
    qmag = (vq < 0) ? -vq : vq;
    rmag = mdiv(qmag, QONE, vs);
    if (rmag > RAT_CAP) rmag = RAT_CAP;
    rterm = (vq < 0) ? -$signed(rmag) : $signed(rmag);
    t = v + TOFF;
    lnv = mdiv(lg2(t), LN2Q, QONE);
    nmag = (v >= HALFQ) ? (v - HALFQ) : (HALFQ - v);
    ratio = $signed(mdiv(nmag, QONE, t));
    if (v < HALFQ) ratio = -ratio;
    y = $signed(lnv) - $signed(QONE) + ratio - rterm;
    x = y + (64'sd1 <<< (SH - 1));
    if (x >= 0) q = $signed(64'(x) >> SH);
    else q = -$signed((64'(-x) + ((64'd1 << SH) - 1)) >> SH);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    res.psi = q[31:0];
    res.derr = 1'b0;
    return res;
  endfunction

  initial begin
    logic [31:0] a;
    arg_q.push_back(32'd0);
    arg_q.push_back(32'd1);
    arg_q.push_back(32'd2);
    arg_q.push_back(32'd3);
    arg_q.push_back(32'hFFFF_FFFF);
    arg_q.push_back(32'hFFFF_FFFE);
    arg_q.push_back(32'h8000_0000);
    arg_q.push_back(32'h7FFF_FFFF);
    arg_q.push_back(32'h0000_8000);
    arg_q.push_back(32'h0001_0000);
    arg_q.push_back(32'h0002_0000);
    arg_q.push_back(32'h0000_FFFF);
    arg_q.push_back(32'h0001_D8AB);
    arg_q.push_back(32'h0000_0100);
    arg_q.push_back(32'h0000_0010);
    arg_q.push_back(32'h0064_0000);
    arg_q.push_back(32'h5555_5555);
    arg_q.push_back(32'hAAAA_AAAA);
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 5))
        0: a = $urandom;
        1: a = $urandom_range(0, 32'h0000_FFFF);
        2: a = $urandom_range(0, 32'h000F_FFFF);
        3: a = $urandom_range(0, 32'h00FF_FFFF);
        4: a = $urandom >> $urandom_range(0, 31);
        default: a = (i % 40 == 0) ? 32'd0 : $urandom_range(1, 64);
      endcase
      arg_q.push_back(a);
    end
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !busy) void'(arg_q.pop_front());
      if (arg_q.size() == 0) begin
        start <= 1'b0;
        stim_done <= 1'b1;
      end else begin
        if ($urandom_range(0, 299) == 0) calm <= ~calm;
        if (calm || $urandom_range(0, 99) >= 27) begin
          start <= 1'b1;
          in_argument <= arg_q[0];
        end else begin
          start <= 1'b0;
          in_argument <= $urandom;
        end
      end
    end
  end

  always @(posedge clk) begin
    psi_res_t e;
    if (rst_n && start && !busy) psi_expect_q.push_back(digamma_of(in_argument));
    if (rst_n && out_strobe) begin
      if (psi_expect_q.size() == 0) begin
        $error("unexpected transaction: value %0d", out_digamma_value);
        n_fail++;
      end else begin
        e = psi_expect_q.pop_front();
        if (out_digamma_value !== e.psi) begin
          $error("digamma_value: expected %0d, got %0d", e.psi, out_digamma_value);
          n_fail++;
        end
        if (out_domain_error !== e.derr) begin
          $error("domain_error: expected %0d, got %0d", e.derr, out_domain_error);
          n_fail++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (psi_expect_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_fail == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #200000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
